/* sv/assert_macros.svh */
// concurrent assertion helpers, clocked on clk_i and quiet while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/sha_pkg.sv */
`timescale 1ns / 1ps

package sha_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned LenW    = 64;
  localparam int unsigned FillW   = 6;
  localparam int unsigned RoundW  = 6;
  localparam int unsigned WidxW   = 3;
  localparam int unsigned BlkWords = 16;
  localparam int unsigned HashWords = 8;

  localparam logic [RoundW-1:0] RoundLast   = 6'd63;
  localparam logic [WidxW-1:0]  WordIdxLast = 3'd7;
  localparam logic [FillW-1:0]  FillLast    = 6'd63;
  localparam logic [FillW-1:0]  LenPos      = 6'd56;
  localparam logic [ByteW-1:0]  PadByte     = 8'h80;
  localparam logic [LenW-1:0]   BitsPerByte = 64'd8;

  localparam logic [WordW-1:0] RoundK [64] = '{
    32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
    32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
    32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
    32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
    32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
    32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
    32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
    32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
    32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
    32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
    32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
    32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
    32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
    32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
    32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
    32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
  };

  localparam logic [WordW-1:0] HashInit [HashWords] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  // controller to datapath
  typedef struct packed {
    logic              put_byte;
    logic              pad;
    logic              pad2;
    logic              start;
    logic              round;
    logic              fold;
    logic              clr_len;
    logic              reinit;
    logic [RoundW-1:0] rnd;
    logic [WidxW-1:0]  word_idx;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic fill_wrap;
    logic fill_high;
  } sts_t;

endpackage

/* sv/sha_stream_if.sv */
`timescale 1ns / 1ps

interface sha_in_if;
  import sha_pkg::*;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] data_byte;
  logic             byte_present;
  logic             last_byte;

  modport source (output valid, data_byte, byte_present, last_byte, input ready);
  modport sink (input valid, data_byte, byte_present, last_byte, output ready);
endinterface

interface sha_out_if;
  import sha_pkg::*;
  logic             valid;
  logic             ready;
  logic [WordW-1:0] digest_word;
  logic [WidxW-1:0] word_index;
  logic             last_word;

  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

/* sv/sha_dp.sv */
`timescale 1ns / 1ps

module sha_dp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  sha_pkg::cmd_t              cmd_i,
  input  logic [sha_pkg::ByteW-1:0]  data_byte_i,
  output sha_pkg::sts_t              sts_o,
  output logic [sha_pkg::WordW-1:0]  digest_word_o
);
  import sha_pkg::*;

  function automatic logic [WordW-1:0] rotr(input logic [WordW-1:0] x, input int n);
    return (x >> n) | (x << (WordW - n));
  endfunction

  function automatic logic [WordW-1:0] bsig0(input logic [WordW-1:0] x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [WordW-1:0] bsig1(input logic [WordW-1:0] x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [WordW-1:0] ssig0(input logic [WordW-1:0] x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [WordW-1:0] ssig1(input logic [WordW-1:0] x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  logic [WordW-1:0] w_q    [BlkWords];
  logic [WordW-1:0] w_d    [BlkWords];
  logic [WordW-1:0] vars_q [HashWords];
  logic [WordW-1:0] vars_d [HashWords];
  logic [WordW-1:0] h_q    [HashWords];
  logic [WordW-1:0] h_d    [HashWords];
  logic [LenW-1:0]  len_q, len_d;
  logic [FillW-1:0] fill_q, fill_d;

  logic [WordW-1:0] t1, t2, w_next;
  logic [4:0]       lane_sh;

  assign sts_o.fill_wrap = (fill_q == FillLast);
  assign sts_o.fill_high = (fill_q >= LenPos);
  assign digest_word_o   = h_q[cmd_i.word_idx];

  // big-endian lane: byte 0 of a word sits in bits 31:24
  assign lane_sh = {~fill_q[1:0], 3'b000};

  assign t1 = vars_q[7] + bsig1(vars_q[4])
            + ((vars_q[4] & vars_q[5]) ^ (~vars_q[4] & vars_q[6]))
            + RoundK[cmd_i.rnd] + w_q[0];
  assign t2 = bsig0(vars_q[0])
            + ((vars_q[0] & vars_q[1]) ^ (vars_q[0] & vars_q[2]) ^ (vars_q[1] & vars_q[2]));
  assign w_next = ssig1(w_q[14]) + w_q[9] + ssig0(w_q[1]) + w_q[0];

  always_comb begin
    logic [FillW-1:0] pos;
    pos    = '0;
    w_d    = w_q;
    vars_d = vars_q;
    h_d    = h_q;
    len_d  = len_q;
    fill_d = fill_q;

    if (cmd_i.put_byte) begin
      if (fill_q[1:0] == 2'd0) begin
        w_d[fill_q[5:2]] = {data_byte_i, 24'h0};
      end else begin
        w_d[fill_q[5:2]][lane_sh +: ByteW] = data_byte_i;
      end
      len_d  = len_q + BitsPerByte;
      fill_d = fill_q + 6'd1;
    end

    if (cmd_i.pad) begin
      for (int i = 0; i < BlkWords; i++) begin
        for (int j = 0; j < 4; j++) begin
          pos = FillW'(4 * i + j);
          if (pos == fill_q) begin
            w_d[i][8*(3-j) +: ByteW] = PadByte;
          end else if (pos > fill_q) begin
            w_d[i][8*(3-j) +: ByteW] = '0;
          end
        end
      end
      if (!sts_o.fill_high) begin
        w_d[14] = len_q[LenW-1:WordW];
        w_d[15] = len_q[WordW-1:0];
      end
    end

    if (cmd_i.pad2) begin
      for (int i = 0; i < BlkWords; i++) begin
        w_d[i] = '0;
      end
      w_d[14] = len_q[LenW-1:WordW];
      w_d[15] = len_q[WordW-1:0];
    end

    if (cmd_i.start) begin
      vars_d = h_q;
    end

    if (cmd_i.round) begin
      vars_d[7] = vars_q[6];
      vars_d[6] = vars_q[5];
      vars_d[5] = vars_q[4];
      vars_d[4] = vars_q[3] + t1;
      vars_d[3] = vars_q[2];
      vars_d[2] = vars_q[1];
      vars_d[1] = vars_q[0];
      vars_d[0] = t1 + t2;
      // schedule window slides so w_q[0] is always the current round word
      for (int i = 0; i < BlkWords - 1; i++) begin
        w_d[i] = w_q[i+1];
      end
      w_d[BlkWords-1] = w_next;
    end

    if (cmd_i.fold) begin
      for (int i = 0; i < HashWords; i++) begin
        h_d[i] = h_q[i] + vars_q[i];
      end
    end

    if (cmd_i.clr_len) begin
      len_d  = '0;
      fill_d = '0;
    end

    if (cmd_i.reinit) begin
      h_d = HashInit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q    <= HashInit;
      len_q  <= '0;
      fill_q <= '0;
    end else begin
      h_q    <= h_d;
      len_q  <= len_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q    <= w_d;
    vars_q <= vars_d;
  end

endmodule

/* sv/sha_ctrl.sv */
`timescale 1ns / 1ps

module sha_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          byte_present_i,
  input  logic          last_byte_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  sha_pkg::sts_t sts_i,
  output sha_pkg::cmd_t cmd_o
);
  import sha_pkg::*;

  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SRound = 3'd1;
  localparam logic [2:0] SFold  = 3'd2;
  localparam logic [2:0] SPad   = 3'd3;
  localparam logic [2:0] SPad2  = 3'd4;
  localparam logic [2:0] SOut   = 3'd5;

  logic [2:0]        state_q, state_d;
  logic [2:0]        nxt_q, nxt_d;
  logic [RoundW-1:0] rnd_q, rnd_d;
  logic [WidxW-1:0]  widx_q, widx_d;
  logic              accept;

  assign in_ready_o  = (state_q == SIdle);
  assign out_valid_o = (state_q == SOut);
  assign accept      = in_valid_i & in_ready_o;

  always_comb begin
    state_d = state_q;
    nxt_d   = nxt_q;
    rnd_d   = rnd_q;
    widx_d  = widx_q;
    cmd_o   = '0;
    cmd_o.rnd      = rnd_q;
    cmd_o.word_idx = widx_q;

    case (state_q)
      SIdle: begin
        if (accept) begin
          cmd_o.put_byte = byte_present_i;
          if (byte_present_i && sts_i.fill_wrap) begin
            // block is full: compress first, pad afterwards if this ended the message
            cmd_o.start = 1'b1;
            rnd_d       = '0;
            nxt_d       = last_byte_i ? SPad : SIdle;
            state_d     = SRound;
          end else if (last_byte_i) begin
            state_d = SPad;
          end
        end
      end
      SPad: begin
        cmd_o.pad   = 1'b1;
        cmd_o.start = 1'b1;
        rnd_d       = '0;
        nxt_d       = sts_i.fill_high ? SPad2 : SOut;
        state_d     = SRound;
      end
      SPad2: begin
        cmd_o.pad2  = 1'b1;
        cmd_o.start = 1'b1;
        rnd_d       = '0;
        nxt_d       = SOut;
        state_d     = SRound;
      end
      SRound: begin
        cmd_o.round = 1'b1;
        rnd_d       = rnd_q + 6'd1;
        if (rnd_q == RoundLast) begin
          state_d = SFold;
        end
      end
      SFold: begin
        cmd_o.fold    = 1'b1;
        cmd_o.clr_len = (nxt_q == SOut);
        widx_d        = '0;
        state_d       = nxt_q;
      end
      SOut: begin
        if (out_ready_i) begin
          if (widx_q == WordIdxLast) begin
            cmd_o.reinit = 1'b1;
            state_d      = SIdle;
          end else begin
            widx_d = widx_q + 3'd1;
          end
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      nxt_q   <= SIdle;
      rnd_q   <= '0;
      widx_q  <= '0;
    end else begin
      state_q <= state_d;
      nxt_q   <= nxt_d;
      rnd_q   <= rnd_d;
      widx_q  <= widx_d;
    end
  end

endmodule

/* sv/sha256_stream_hash.sv */
`timescale 1ns / 1ps
// SHA-256 over a byte stream. Each input transfer carries at most one message byte; last_byte
// ends the message and an empty message is one transfer with byte_present low. The byte that
// completes a 64-byte block starts the compression, which runs one round per cycle on a single
// round unit: 64 rounds, then a fold step that adds the result into the hash, so input is not
// ready again until the fold is done. At end of message the padding is loaded and compressed
// (twice when 56 or more bytes sit in the last block), and the eight digest words follow, H0
// first, one per output transfer. Input is held off until the eighth word has been taken; the
// hash then returns to its initial value.
module sha256_stream_hash (
  input logic       clk_i,
  input logic       rst_ni,
  sha_in_if.sink    in_i,
  sha_out_if.source out_o
);
  import sha_pkg::*;

  cmd_t cmd;
  sts_t sts;

  sha_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_i.valid),
    .in_ready_o     (in_i.ready),
    .byte_present_i (in_i.byte_present),
    .last_byte_i    (in_i.last_byte),
    .out_valid_o    (out_o.valid),
    .out_ready_i    (out_o.ready),
    .sts_i          (sts),
    .cmd_o          (cmd)
  );

  sha_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .data_byte_i   (in_i.data_byte),
    .sts_o         (sts),
    .digest_word_o (out_o.digest_word)
  );

  assign out_o.word_index = cmd.word_idx;
  assign out_o.last_word  = (cmd.word_idx == WordIdxLast);

`include "assert_macros.svh"

  `ASSERT_IMPL(a_no_overlap, in_i.ready, !out_o.valid, "input ready while digest pending")
  `ASSERT_NEXT(a_back_idle, out_o.valid && out_o.ready && out_o.last_word,
               in_i.ready, "not idle after digest")
  `ASSERT_NEXT(a_word_step, out_o.valid && out_o.ready && !out_o.last_word,
               out_o.valid && (out_o.word_index == $past(out_o.word_index) + 3'd1),
               "digest word order broken")

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import sha_pkg::*;

  localparam int unsigned CycleLimit  = 2000000;
  localparam int unsigned RandItems   = 380;
  localparam int unsigned TailCycles  = 150;

  typedef struct packed {
    logic [WordW-1:0] word;
    logic [WidxW-1:0] idx;
    logic             last;
  } digest_item_t;

  // running SHA-256 of the byte stream, plus the digest words still owed
  class digest_scoreboard;
    logic [WordW-1:0] chain_val [HashWords];
    logic [WordW-1:0] block_buf [BlkWords];
    logic [LenW-1:0]  msg_bits;
    logic [FillW-1:0] fill;
    digest_item_t     digest_q [$];
    int               err_count;

    function new();
      err_count = 0;
      restart();
    endfunction

    function void restart();
      for (int j = 0; j < HashWords; j++) chain_val[j] = HashInit[j];
      msg_bits = '0;
      fill     = '0;
    endfunction

    function logic [WordW-1:0] rotr(logic [WordW-1:0] x, int n);
      return (x >> n) | (x << (WordW - n));
    endfunction

    function void put_byte(int pos, logic [ByteW-1:0] b);
      block_buf[pos / 4][(3 - (pos % 4)) * 8 +: 8] = b;
    endfunction

    function void compress();
      logic [WordW-1:0] w [BlkWords];
      logic [WordW-1:0] v [HashWords];
      logic [WordW-1:0] x1, x14, s0, s1, t1, t2;
      for (int j = 0; j < BlkWords; j++) w[j] = block_buf[j];
      for (int j = 0; j < HashWords; j++) v[j] = chain_val[j];
      for (int r = 0; r < 64; r++) begin
        if (r >= 16) begin
          x1  = w[(r + 1) % 16];
          x14 = w[(r + 14) % 16];
          s0  = rotr(x1, 7) ^ rotr(x1, 18) ^ (x1 >> 3);
          s1  = rotr(x14, 17) ^ rotr(x14, 19) ^ (x14 >> 10);
          w[r % 16] = w[r % 16] + s0 + s1 + w[(r + 9) % 16];
        end
        t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
             + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[r] + w[r % 16];
        t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
             + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        v[7] = v[6];
        v[6] = v[5];
        v[5] = v[4];
        v[4] = v[3] + t1;
        v[3] = v[2];
        v[2] = v[1];
        v[1] = v[0];
        v[0] = t1 + t2;
      end
      for (int j = 0; j < HashWords; j++) chain_val[j] = chain_val[j] + v[j];
    endfunction

    function void note_transfer(logic [ByteW-1:0] d, logic present, logic last);
      int pos;
      digest_item_t item;
      if (present) begin
        put_byte(int'(fill), d);
        msg_bits = msg_bits + BitsPerByte;
        fill     = fill + 6'd1;
        if (fill == '0) compress();
      end
      if (!last) return;
      pos = int'(fill);
      put_byte(pos, PadByte);
      pos++;
      // length no longer fits, spill into a second padding block
      if (pos > int'(LenPos)) begin
        while (pos < 64) begin
          put_byte(pos, '0);
          pos++;
        end
        compress();
        pos = 0;
      end
      while (pos < int'(LenPos)) begin
        put_byte(pos, '0);
        pos++;
      end
      block_buf[14] = msg_bits[63:32];
      block_buf[15] = msg_bits[31:0];
      compress();
      for (int k = 0; k < HashWords; k++) begin
        item.word = chain_val[k];
        item.idx  = k[WidxW-1:0];
        item.last = (k[WidxW-1:0] == WordIdxLast);
        digest_q.push_back(item);
      end
      restart();
    endfunction

    function void check_word(logic [WordW-1:0] w, logic [WidxW-1:0] idx, logic last);
      digest_item_t exp_item;
      if (digest_q.size() == 0) begin
        $error("unexpected digest word %h index %0d", w, idx);
        err_count++;
        return;
      end
      exp_item = digest_q.pop_front();
      if (w !== exp_item.word) begin
        $error("digest_word expected %h actual %h", exp_item.word, w);
        err_count++;
      end
      if (idx !== exp_item.idx) begin
        $error("word_index expected %0d actual %0d", exp_item.idx, idx);
        err_count++;
      end
      if (last !== exp_item.last) begin
        $error("last_word expected %0b actual %0b", exp_item.last, last);
        err_count++;
      end
    endfunction

    function int pending();
      return digest_q.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  sha_in_if  in_if ();
  sha_out_if out_if ();

  sha256_stream_hash u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if.sink),
    .out_o  (out_if.source)
  );

  digest_scoreboard sb;
  int unsigned      items_sent;
  int unsigned      cycle_count;
  bit               burst;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int pick_len();
    int r;
    int edge_lens [9];
    edge_lens = '{55, 56, 57, 63, 64, 65, 119, 120, 128};
    r = $urandom_range(0, 99);
    if (r < 50) return $urandom_range(0, 10);
    if (r < 75) return edge_lens[$urandom_range(0, 8)];
    return $urandom_range(11, 130);
  endfunction

  // entered and left at a falling edge
  task automatic send_item(logic [ByteW-1:0] d, logic present, logic last);
    int gap;
    gap = burst ? 0 : gap_len();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.data_byte    <= d;
    in_if.byte_present <= present;
    in_if.last_byte    <= last;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_transfer(d, present, last);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_message(int len, bit sep_end, bit noisy);
    for (int i = 0; i < len; i++) begin
      if (noisy && $urandom_range(0, 4) == 0)
        send_item(ByteW'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_item(ByteW'($urandom_range(0, 255)), 1'b1, (i == len - 1) && !sep_end);
    end
    if (len == 0 || sep_end) send_item(ByteW'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  task automatic drain_digests();
    in_if.valid <= 1'b0;
    do @(negedge clk_i); while (sb.pending() != 0);
  endtask

  initial begin
    int run;
    out_if.ready = 1'b0;
    forever begin
      run = $urandom_range(1, 24);
      repeat (run) begin
        @(negedge clk_i);
        out_if.ready <= 1'b1;
      end
      run = gap_len();
      repeat (run) begin
        @(negedge clk_i);
        out_if.ready <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready)
      sb.check_word(out_if.digest_word, out_if.word_index, out_if.last_word);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    cycle_count        = 0;
    items_sent         = 0;
    burst              = 1'b0;
    rst_ni             = 1'b0;
    in_if.valid        = 1'b0;
    in_if.data_byte    = '0;
    in_if.byte_present = 1'b0;
    in_if.last_byte    = 1'b0;
    sb                 = new();
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty message, then a transfer that carries nothing
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hA5, 1'b0, 1'b0);
    // bytes at both extremes, message closed by a transfer without a byte
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'h5A, 1'b0, 1'b1);
    send_item(8'hFF, 1'b1, 1'b1);
    // "abc" with an idle transfer in the middle
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    send_item(8'h00, 1'b1, 1'b1);
    // 56-byte message forces the length into a second padding block
    burst = 1'b1;
    send_message(56, 1'b0, 1'b0);
    burst = 1'b0;

    // hold the sender back until every digest word is out
    drain_digests();

    while (items_sent < RandItems) begin
      burst = ($urandom_range(0, 4) == 0);
      send_message(pick_len(), $urandom_range(0, 3) == 0, $urandom_range(0, 2) == 0);
    end

    drain_digests();
    repeat (TailCycles) @(negedge clk_i);
    if (sb.err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
